FILE: design/page_map_table_walk_defines.svh
// ----------------------------------------------------------------------------
// page_map_table_walk_defines
// Assertion macros used by the page map RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_MAP_TABLE_WALK_DEFINES_SVH
`define PAGE_MAP_TABLE_WALK_DEFINES_SVH

`ifndef SYNTH
`define PMTW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("page map assertion failed");
`define PMTW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("page map assertion failed");
`else
`define PMTW_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PMTW_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/pmtw_pkg.sv
// ----------------------------------------------------------------------------
// pmtw_pkg
// Types and constants of the page map table walk.
// ----------------------------------------------------------------------------
`default_nettype none

package pmtw_pkg;

	localparam int ADDR_W         = 48;
	localparam int WORD_W         = 64;
	localparam int RIDX_W         = 6;
	localparam int ENTRIES_DEF    = 16;
	localparam int PAGE_SHIFT_DEF = 12;

	typedef enum logic [1:0] {
		MODE_WALK     = 2'd0,
		MODE_CREATE   = 2'd1,
		MODE_WRITE    = 2'd2,
		MODE_TRAVERSE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  vaddr;
		logic [ADDR_W-1:0]  last_vaddr;
		logic [RIDX_W-1:0]  slot_index;
		logic [WORD_W-1:0]  entry_word;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic               found;
		logic [RIDX_W-1:0]  result_index;
		logic [WORD_W-1:0]  result_word;
		logic [ADDR_W-1:0]  result_page;
		logic               last;
	} out_item_t;

endpackage

`default_nettype wire

FILE: design/pmtw_store.sv
// ----------------------------------------------------------------------------
// pmtw_store
// Slot memory, one read and one write port, registered read data.
// Per-slot valid flops make unwritten slots read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtw_store #(
	parameter int ENTRIES = pmtw_pkg::ENTRIES_DEF,
	parameter int DATA_W  = pmtw_pkg::WORD_W + pmtw_pkg::ADDR_W - pmtw_pkg::PAGE_SHIFT_DEF,
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0]  mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [DATA_W-1:0]  rdata_s1;
	logic               rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_s1 ? rdata_s1 : '0;

endmodule

`default_nettype wire

FILE: design/page_map_table_walk.sv
// ----------------------------------------------------------------------------
// page_map_table_walk
// Fully associative page map: walk, walk and create, write, range traverse.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. busy drops at the
//   edge that puts the last result of the item on result, so the next item
//   can be taken in the cycle that result is strobed. Each result is on
//   result for one cycle with result_strobe high; the receiver cannot stall.
//   Walk / create: slots are read one per cycle from the slot memory; a hit
//   ends the scan early. Write: the slot is read and, when slot_index is
//   below ENTRIES, written back. Traverse: one result per matching slot,
//   the last one strobed after the scan; no match gives a single not-found
//   result. The single memory read port sets the rate: one slot per cycle.
//   Reset clears the per-slot valid flops at once, so all slots read as
//   empty right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_map_table_walk_defines.svh"

module page_map_table_walk #(
	parameter int ENTRIES    = pmtw_pkg::ENTRIES_DEF,
	parameter int PAGE_SHIFT = pmtw_pkg::PAGE_SHIFT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire pmtw_pkg::in_item_t  item,
	output pmtw_pkg::out_item_t      result,
	output logic                     result_strobe
);

	import pmtw_pkg::*;

	localparam int PN_W   = ADDR_W - PAGE_SHIFT;
	localparam int DATA_W = PN_W + WORD_W;
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	state_t             state_q, state_d;
	mode_t              mode_q;
	logic [ADDR_W-1:0]  va_q, lva_q;
	logic [RIDX_W-1:0]  sidx_q;
	logic [WORD_W-1:0]  word_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               data_vld_s1;
	logic [IDX_W-1:0]   data_idx_s1;
	logic               found_free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               pend_vld_q;
	out_item_t          pend_q;
	out_item_t          res_q;
	logic               strobe_q;

	logic               accept;
	logic               rd_en, wr_en;
	logic [IDX_W-1:0]   rd_addr, wr_addr;
	logic [DATA_W-1:0]  rd_data, wr_data;
	logic [PN_W-1:0]    ent_page, pnum;
	logic [WORD_W-1:0]  ent_word;
	logic [ADDR_W-1:0]  ent_base;
	logic               present, hit, tmatch, last_data, in_range;
	logic               free_now, set_free, load_pend, emit;
	logic [IDX_W-1:0]   free_sel;
	out_item_t          emit_item, ent_item, empty_item;

	pmtw_store #(
		.ENTRIES (ENTRIES),
		.DATA_W  (DATA_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign ent_page  = rd_data[DATA_W-1:WORD_W];
	assign ent_word  = rd_data[WORD_W-1:0];
	assign ent_base  = {ent_page, {PAGE_SHIFT{1'b0}}};
	assign present   = ent_word[0];
	assign pnum      = va_q[ADDR_W-1:PAGE_SHIFT];
	assign hit       = present && (ent_page == pnum);
	assign tmatch    = present && (ent_base >= va_q) && (ent_base <= lva_q);
	assign last_data = (data_idx_s1 == IDX_W'(ENTRIES - 1));
	assign in_range  = ({1'b0, sidx_q} < (RIDX_W + 1)'(ENTRIES));
	assign free_now  = found_free_q || !present;
	assign free_sel  = found_free_q ? free_idx_q : data_idx_s1;

	always_comb begin
		empty_item      = '0;
		empty_item.last = 1'b1;
		ent_item              = '0;
		ent_item.found        = 1'b1;
		ent_item.result_index = RIDX_W'(data_idx_s1);
		ent_item.result_word  = ent_word;
		ent_item.result_page  = ent_base;
		ent_item.last         = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.mode == MODE_WRITE) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (data_vld_s1) begin
					if (mode_q == MODE_TRAVERSE) begin
						if (last_data) begin
							state_d = ST_FLUSH;
						end
					end else if (hit || last_data) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		emit      = 1'b0;
		emit_item = empty_item;
		set_free  = 1'b0;
		load_pend = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_en   = 1'b1;
					rd_addr = (item.mode == MODE_WRITE) ? item.slot_index[IDX_W-1:0] : '0;
				end
			end
			ST_SCAN: begin
				rd_en   = (rd_cnt_q < CNT_W'(ENTRIES));
				rd_addr = rd_cnt_q[IDX_W-1:0];
				if (data_vld_s1) begin
					case (mode_q)
						MODE_TRAVERSE: begin
							if (tmatch) begin
								load_pend = 1'b1;
								if (pend_vld_q) begin
									emit           = 1'b1;
									emit_item      = pend_q;
									emit_item.last = 1'b0;
								end
							end
						end
						default: begin
							set_free = !present && !found_free_q;
							if (hit) begin
								emit      = 1'b1;
								emit_item = ent_item;
							end else if (last_data) begin
								emit = 1'b1;
								if (mode_q == MODE_CREATE) begin
									if (free_now) begin
										wr_en   = 1'b1;
										wr_addr = free_sel;
										wr_data = {pnum, {WORD_W{1'b0}}};
										emit_item.found        = 1'b1;
										emit_item.result_index = RIDX_W'(free_sel);
										emit_item.result_page  = {pnum, {PAGE_SHIFT{1'b0}}};
									end else begin
										emit_item.status = 1'b1;
									end
								end
							end
						end
					endcase
				end
			end
			ST_WRITE: begin
				emit = 1'b1;
				if (in_range) begin
					wr_en   = 1'b1;
					wr_addr = sidx_q[IDX_W-1:0];
					wr_data = {ent_page, word_q};
					emit_item.found        = 1'b1;
					emit_item.result_index = sidx_q;
					emit_item.result_word  = word_q;
					emit_item.result_page  = ent_base;
				end
			end
			ST_FLUSH: begin
				emit = 1'b1;
				if (pend_vld_q) begin
					emit_item = pend_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			strobe_q     <= 1'b0;
			rd_cnt_q     <= '0;
			data_vld_s1  <= 1'b0;
			found_free_q <= 1'b0;
			pend_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			strobe_q    <= emit;
			data_vld_s1 <= rd_en && (state_q == ST_SCAN || (accept && item.mode != MODE_WRITE));
			if (accept) begin
				rd_cnt_q     <= CNT_W'(1);
				found_free_q <= 1'b0;
				pend_vld_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (set_free) begin
					found_free_q <= 1'b1;
				end
				if (load_pend) begin
					pend_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			va_q   <= item.vaddr;
			lva_q  <= item.last_vaddr;
			sidx_q <= item.slot_index;
			word_q <= item.entry_word;
		end
		if (rd_en) begin
			data_idx_s1 <= rd_addr;
		end
		if (set_free) begin
			free_idx_q <= data_idx_s1;
		end
		if (load_pend) begin
			pend_q <= ent_item;
		end
		if (emit) begin
			res_q <= emit_item;
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

	`PMTW_ASSERT_IMP(a_empty_zero, clk, arst_n, result_strobe && !result.found,
		result.result_word == '0 && result.result_page == '0 && result.result_index == '0)
	`PMTW_ASSERT_IMP(a_multi_only_traverse, clk, arst_n, result_strobe && !result.last,
		mode_q == MODE_TRAVERSE)
	`PMTW_ASSERT_IMP(a_strobe_after_busy, clk, arst_n, result_strobe, $past(busy))

endmodule

`default_nettype wire

FILE: sim/page_map_table_walk_test.sv
// ----------------------------------------------------------------------------
// page_map_table_walk_test
// Self-checking bench for the page map: a queue-fed driver issues walk,
// create, write and traverse items under varying sender gaps, while a
// monitor predicts each accepted item against a shadow copy of the slot
// store and checks every strobed result in order.
// ----------------------------------------------------------------------------
module page_map_table_walk_test;
	import pmtw_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int PAGE_SHIFT   = PAGE_SHIFT_DEF;
	localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
	localparam int POOL_SIZE    = 12;
	localparam int RANDOM_ITEMS = 170;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
	localparam logic [WORD_W-1:0] WORD_MAX = '1;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	out_item_t result;
	logic      result_strobe;

	in_item_t          pending_items[$];
	out_item_t         expected_results[$];
	logic [PAGE_W-1:0] map_page[ENTRIES];
	logic [WORD_W-1:0] map_word[ENTRIES];
	logic [PAGE_W-1:0] page_pool[POOL_SIZE];
	int                issued       = 0;
	int                taken        = 0;
	int                errors       = 0;
	int                stall_cycles = 0;

	page_map_table_walk u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_strobe(result_strobe)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic out_item_t mk_result(logic status, logic found, int idx,
			logic [WORD_W-1:0] word, logic [ADDR_W-1:0] page, logic last);
		out_item_t r;
		r.status       = status;
		r.found        = found;
		r.result_index = RIDX_W'(idx);
		r.result_word  = word;
		r.result_page  = page;
		r.last         = last;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_base(int i);
		return {map_page[i], {PAGE_SHIFT{1'b0}}};
	endfunction

	function automatic logic slot_listed(int i, in_item_t it);
		return map_word[i][0] && slot_base(i) >= it.vaddr && slot_base(i) <= it.last_vaddr;
	endfunction

	// shadow page map: update state and queue the results of one item
	task automatic map_apply(input in_item_t it);
		logic [PAGE_W-1:0] pnum;
		int                hit_idx;
		int                free_idx;
		int                last_idx;
		int                widx;
		pnum     = it.vaddr[ADDR_W-1:PAGE_SHIFT];
		hit_idx  = -1;
		free_idx = -1;
		last_idx = -1;
		widx     = int'(it.slot_index);
		case (it.mode)
			MODE_WRITE: begin
				if (widx >= ENTRIES) begin
					expected_results.push_back(mk_result(0, 0, 0, '0, '0, 1));
				end else begin
					map_word[widx] = it.entry_word;
					expected_results.push_back(mk_result(0, 1, widx,
						it.entry_word, slot_base(widx), 1));
				end
			end
			MODE_TRAVERSE: begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_listed(i, it))
						last_idx = i;
				if (last_idx < 0)
					expected_results.push_back(mk_result(0, 0, 0, '0, '0, 1));
				for (int i = 0; i < ENTRIES; i++)
					if (slot_listed(i, it))
						expected_results.push_back(mk_result(0, 1, i, map_word[i],
							slot_base(i), i == last_idx));
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (map_word[i][0]) begin
						if (hit_idx < 0 && map_page[i] == pnum)
							hit_idx = i;
					end else if (free_idx < 0) begin
						free_idx = i;
					end
				end
				if (hit_idx >= 0) begin
					expected_results.push_back(mk_result(0, 1, hit_idx, map_word[hit_idx],
						slot_base(hit_idx), 1));
				end else if (it.mode == MODE_WALK) begin
					expected_results.push_back(mk_result(0, 0, 0, '0, '0, 1));
				end else if (free_idx < 0) begin
					expected_results.push_back(mk_result(1, 0, 0, '0, '0, 1));
				end else begin
					map_page[free_idx] = pnum;
					map_word[free_idx] = '0;
					expected_results.push_back(mk_result(0, 1, free_idx, '0,
						slot_base(free_idx), 1));
				end
			end
		endcase
	endtask

	task automatic report(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t: mismatch %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	function automatic in_item_t mk_item(mode_t m, logic [ADDR_W-1:0] va,
			logic [ADDR_W-1:0] lva, int idx, logic [WORD_W-1:0] w);
		in_item_t it;
		it.mode       = m;
		it.vaddr      = va;
		it.last_vaddr = lva;
		it.slot_index = RIDX_W'(idx);
		it.entry_word = w;
		return it;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic logic [ADDR_W-1:0] pool_addr();
		logic [PAGE_SHIFT-1:0] offset;
		offset = ($urandom_range(99) < 30) ? '0 : PAGE_SHIFT'($urandom);
		return {page_pool[$urandom_range(POOL_SIZE - 1)], offset};
	endfunction

	function automatic in_item_t rand_item();
		in_item_t          it;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		int                roll;
		it   = mk_item(MODE_WALK, rand_addr(), rand_addr(), $urandom_range(63),
			{$urandom, $urandom});
		roll = $urandom_range(99);
		if (roll < 25) begin
			it.mode = MODE_WALK;
		end else if (roll < 50) begin
			it.mode = MODE_CREATE;
		end else if (roll < 80) begin
			it.mode = MODE_WRITE;
		end else begin
			it.mode = MODE_TRAVERSE;
		end
		case (it.mode)
			MODE_WRITE: begin
				if ($urandom_range(99) < 85)
					it.slot_index = RIDX_W'($urandom_range(ENTRIES - 1));
				it.entry_word[0] = $urandom_range(99) >= 10;
			end
			MODE_TRAVERSE: begin
				roll = $urandom_range(99);
				a    = pool_addr();
				b    = pool_addr();
				if (roll < 15) begin
					it.vaddr      = '0;
					it.last_vaddr = ADDR_MAX;
				end else if (roll >= 30) begin
					it.vaddr      = (a < b) ? a : b;
					it.last_vaddr = (a < b) ? b : a;
					if (roll >= 90) begin
						it.vaddr      = it.last_vaddr;
						it.last_vaddr = (a < b) ? a : b;
					end
				end
			end
			default: begin
				if ($urandom_range(99) < 85)
					it.vaddr = pool_addr();
			end
		endcase
		return it;
	endfunction

	// driver: new item at the falling edge once the current one is taken
	always @(negedge clk) begin
		int idle_pct;
		idle_pct = (issued < 64) ? 15 : (issued < 128) ? 68 : 0;
		if (arst_n && (!start || taken == issued)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item   <= pending_items.pop_front();
				start  <= 1'b1;
				issued = issued + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		out_item_t want;
		logic      progress;
		if (arst_n) begin
			progress = 1'b0;
			if (result_strobe) begin
				progress = 1'b1;
				if (expected_results.size() == 0) begin
					report("unexpected result, index", WORD_W'(result.result_index), '0);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status)
						report("status", WORD_W'(result.status), WORD_W'(want.status));
					if (result.found !== want.found)
						report("found", WORD_W'(result.found), WORD_W'(want.found));
					if (result.result_index !== want.result_index)
						report("result_index", WORD_W'(result.result_index),
							WORD_W'(want.result_index));
					if (result.result_word !== want.result_word)
						report("result_word", result.result_word, want.result_word);
					if (result.result_page !== want.result_page)
						report("result_page", WORD_W'(result.result_page),
							WORD_W'(want.result_page));
					if (result.last !== want.last)
						report("last", WORD_W'(result.last), WORD_W'(want.last));
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				map_apply(item);
				taken = taken + 1;
			end
			stall_cycles = progress ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("page_map_table_walk_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			map_page[i] = '0;
			map_word[i] = '0;
		end
		page_pool[0] = '0;
		page_pool[1] = '1;
		page_pool[2] = PAGE_W'(5);
		for (int i = 3; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_W'({$urandom, $urandom});

		// directed: empty map, claim without present bit, duplicates, ranges
		pending_items.push_back(mk_item(MODE_WALK, '0, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_TRAVERSE, '0, ADDR_MAX, 0, '0));
		pending_items.push_back(mk_item(MODE_CREATE, '0, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_CREATE, 48'h5000, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 0, WORD_MAX));
		pending_items.push_back(mk_item(MODE_WALK, 48'h5FFF, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_WALK, '0, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_CREATE, ADDR_MAX, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 1, 64'h1));
		pending_items.push_back(mk_item(MODE_WALK, ADDR_MAX, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 63, WORD_MAX));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, ENTRIES, WORD_MAX));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 7, 64'h3));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 9, 64'h1));
		pending_items.push_back(mk_item(MODE_WALK, 48'h123, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_TRAVERSE, 48'h10000, 48'hFFFF, 0, '0));
		pending_items.push_back(mk_item(MODE_TRAVERSE, '0, ADDR_MAX, 0, '0));
		pending_items.push_back(mk_item(MODE_TRAVERSE, 48'h5000, 48'h5000, 0, '0));
		pending_items.push_back(mk_item(MODE_WRITE, '0, '0, 0, WORD_MAX - 1));
		pending_items.push_back(mk_item(MODE_WALK, 48'h5000, '0, 0, '0));
		pending_items.push_back(mk_item(MODE_CREATE, 48'hABCDE000, '0, 0, '0));
		for (int n = 0; n < RANDOM_ITEMS; n++)
			pending_items.push_back(rand_item());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || taken != issued)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("page_map_table_walk_test: done, clean");
		end else begin
			$display("page_map_table_walk_test: done, errors");
		end
		$finish;
	end

endmodule

FILE: page_map_table_walk.f
+incdir+design
design/pmtw_pkg.sv
design/pmtw_store.sv
design/page_map_table_walk.sv
sim/page_map_table_walk_test.sv
